>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the console engine.
// Needs nothing else; every macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ATCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("%m: assertion failed");

// Assertion that is also checked while reset is held.
`define ATCE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset assertion failed");

`endif

>>> sv/atce_pkg.sv
// Types, constants and colour helpers of the ANSI text console engine.
// No dependencies; the design and checker files refer to it by scoped names.
`default_nettype none

package atce_pkg;

  localparam int CELL_W = 9;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int SLOTS  = 3;
  localparam int SLOT_W = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  // Register indexes
  localparam logic [2:0] REG_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_ROWS      = 3'd1;
  localparam logic [2:0] REG_RED_POS   = 3'd2;
  localparam logic [2:0] REG_RED_SIZE  = 3'd3;
  localparam logic [2:0] REG_GREEN_POS = 3'd4;
  localparam logic [2:0] REG_GREEN_SIZE = 3'd5;
  localparam logic [2:0] REG_BLUE_POS  = 3'd6;
  localparam logic [2:0] REG_BLUE_SIZE = 3'd7;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_H   = 8'd72;
  localparam logic [7:0] CH_UP_J   = 8'd74;
  localparam logic [7:0] CH_UP_K   = 8'd75;
  localparam logic [7:0] CH_UP_Z   = 8'd90;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_M   = 8'd109;
  localparam logic [7:0] CH_LO_Z   = 8'd122;
  localparam logic [7:0] CH_TILDE  = 8'd126;

  // Colour selection numbers
  localparam logic [7:0] SGR_FG_LO = 8'd30;
  localparam logic [7:0] SGR_FG_HI = 8'd37;
  localparam logic [7:0] SGR_BG_LO = 8'd40;
  localparam logic [7:0] SGR_BG_HI = 8'd47;
  localparam logic [2:0] IDX_WHITE = 3'd7;
  localparam logic [2:0] IDX_BLACK = 3'd0;
  localparam logic [2:0] IDX_YELLOW = 3'd3;

  localparam logic [7:0] LEVEL_HI = 8'd170;
  localparam logic [7:0] LEVEL_LO = 8'd85;

  typedef enum logic [1:0] {
    OP_GLYPH  = 2'd0,
    OP_FILL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SCROLL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_BRACKET = 2'd0,
    PH_PARAM   = 2'd1,
    PH_FINAL   = 2'd2,
    PH_REJECT  = 2'd3
  } esc_phase_t;

  // One draw command; idx_a is the fg (glyph) or fill colour, idx_b the glyph bg
  typedef struct packed {
    op_t               op;
    logic [7:0]        glyph;
    logic [CELL_W-1:0] c0;
    logic [CELL_W-1:0] r0;
    logic [CELL_W-1:0] c1;
    logic [CELL_W-1:0] r1;
    logic [2:0]        idx_a;
    logic [2:0]        idx_b;
  } cmd_t;

  // All commands caused by one character
  typedef struct packed {
    cmd_t [SLOTS-1:0]  cmd;
    logic [SLOT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [4:0] red_pos;
    logic [3:0] red_size;
    logic [4:0] green_pos;
    logic [3:0] green_size;
    logic [4:0] blue_pos;
    logic [3:0] blue_size;
  } clr_cfg_t;

  function automatic cmd_t mk_cmd(op_t op, logic [7:0] glyph,
                                  logic [CELL_W-1:0] c0, logic [CELL_W-1:0] r0,
                                  logic [CELL_W-1:0] c1, logic [CELL_W-1:0] r1,
                                  logic [2:0] idx_a, logic [2:0] idx_b);
    cmd_t c;
    c.op    = op;
    c.glyph = glyph;
    c.c0    = c0;
    c.r0    = r0;
    c.c1    = c1;
    c.r1    = r1;
    c.idx_a = idx_a;
    c.idx_b = idx_b;
    return c;
  endfunction

  function automatic logic [31:0] chan_field(logic [7:0] v, logic [3:0] size,
                                             logic [4:0] pos);
    logic [7:0] mask;
    mask = (size >= 4'd8) ? 8'hFF : 8'((9'd1 << size[2:0]) - 9'd1);
    return 32'(v & mask) << pos;
  endfunction

  // Palette: black, red, green, yellow, blue, magenta, cyan, white
  function automatic logic [31:0] encode(logic [2:0] idx, clr_cfg_t cfg);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = idx[0] ? LEVEL_HI : 8'd0;
    g = idx[1] ? ((idx == IDX_YELLOW) ? LEVEL_LO : LEVEL_HI) : 8'd0;
    b = idx[2] ? LEVEL_HI : 8'd0;
    return chan_field(r, cfg.red_size, cfg.red_pos)
         | chan_field(g, cfg.green_size, cfg.green_pos)
         | chan_field(b, cfg.blue_size, cfg.blue_pos);
  endfunction

endpackage

`default_nettype wire

>>> sv/ansi_text_console_engine_top.sv
// The first command of a character passes through the queue and the back end's output register.
// Throughput: the input takes one character a cycle while the 2-entry queue has room;
// the back end issues one command a cycle while out_stall is low, and a character yields 1 to 3 commands.
// Reset (rst_n low, synchronous): cursor home, white on black, parser idle,
// 80x25 text, 8-bit channels at 16/8/0; no clearing pass.
// Holds the configuration registers and joins front end, queue and back end.
`default_nettype none

module ansi_text_console_engine_top #(
  parameter int ESC_LIMIT = 32,
  parameter int MAX_CELLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_op,
  output logic [7:0]                  out_glyph_code,
  output logic [atce_pkg::CELL_W-1:0] out_col_start,
  output logic [atce_pkg::CELL_W-1:0] out_row_start,
  output logic [atce_pkg::CELL_W-1:0] out_col_end,
  output logic [atce_pkg::CELL_W-1:0] out_row_end,
  output logic [31:0]                 out_fg_color,
  output logic [31:0]                 out_bg_color,
  output logic [31:0]                 out_fill_color,
  output logic                        out_last,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [atce_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [atce_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [atce_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic [atce_pkg::CELL_W-1:0] columns_r, rows_r;
  atce_pkg::clr_cfg_t          clr_r;
  logic [2:0]                  reg_idx;
  logic                        wr_en;

  logic             q_full, q_nonempty, q_push, q_pop;
  atce_pkg::entry_t q_wdata, q_head;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r          <= atce_pkg::CELL_W'(80);
      rows_r             <= atce_pkg::CELL_W'(25);
      clr_r.red_pos      <= 5'd16;
      clr_r.red_size     <= 4'd8;
      clr_r.green_pos    <= 5'd8;
      clr_r.green_size   <= 4'd8;
      clr_r.blue_pos     <= 5'd0;
      clr_r.blue_size    <= 4'd8;
    end else if (wr_en) begin
      unique case (reg_idx)
        atce_pkg::REG_COLUMNS:    columns_r        <= cfg_pwdata[8:0];
        atce_pkg::REG_ROWS:       rows_r           <= cfg_pwdata[8:0];
        atce_pkg::REG_RED_POS:    clr_r.red_pos    <= cfg_pwdata[4:0];
        atce_pkg::REG_RED_SIZE:   clr_r.red_size   <= cfg_pwdata[3:0];
        atce_pkg::REG_GREEN_POS:  clr_r.green_pos  <= cfg_pwdata[4:0];
        atce_pkg::REG_GREEN_SIZE: clr_r.green_size <= cfg_pwdata[3:0];
        atce_pkg::REG_BLUE_POS:   clr_r.blue_pos   <= cfg_pwdata[4:0];
        atce_pkg::REG_BLUE_SIZE:  clr_r.blue_size  <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      atce_pkg::REG_COLUMNS:    cfg_prdata = atce_pkg::DATA_W'(columns_r);
      atce_pkg::REG_ROWS:       cfg_prdata = atce_pkg::DATA_W'(rows_r);
      atce_pkg::REG_RED_POS:    cfg_prdata = atce_pkg::DATA_W'(clr_r.red_pos);
      atce_pkg::REG_RED_SIZE:   cfg_prdata = atce_pkg::DATA_W'(clr_r.red_size);
      atce_pkg::REG_GREEN_POS:  cfg_prdata = atce_pkg::DATA_W'(clr_r.green_pos);
      atce_pkg::REG_GREEN_SIZE: cfg_prdata = atce_pkg::DATA_W'(clr_r.green_size);
      atce_pkg::REG_BLUE_POS:   cfg_prdata = atce_pkg::DATA_W'(clr_r.blue_pos);
      atce_pkg::REG_BLUE_SIZE:  cfg_prdata = atce_pkg::DATA_W'(clr_r.blue_size);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign in_stall = q_full;

  atce_front #(
    .ESC_LIMIT (ESC_LIMIT),
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_valid && !q_full),
    .char_code (in_char_code),
    .columns   (columns_r),
    .rows      (rows_r),
    .push      (q_push),
    .entry     (q_wdata)
  );

  atce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_head),
    .nonempty (q_nonempty)
  );

  atce_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clr_cfg        (clr_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_op         (out_op),
    .out_glyph_code (out_glyph_code),
    .out_col_start  (out_col_start),
    .out_row_start  (out_row_start),
    .out_col_end    (out_col_end),
    .out_row_end    (out_row_end),
    .out_fg_color   (out_fg_color),
    .out_bg_color   (out_bg_color),
    .out_fill_color (out_fill_color),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> sv/atce_queue.sv
// Two-entry command queue between the console front end and back end.
// Depends on atce_pkg for the entry type and depth.
`default_nettype none

module atce_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  atce_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output atce_pkg::entry_t rdata,
  output logic             nonempty
);

  atce_pkg::entry_t mem_r [atce_pkg::Q_DEPTH];
  logic [atce_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [atce_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [atce_pkg::Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (atce_pkg::Q_PTR_W+1)'(atce_pkg::Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (atce_pkg::Q_PTR_W+1)'(push) - (atce_pkg::Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> sv/atce_front.sv
// Front end: escape parser, cursor and colour state; turns each character
// into a queue entry of up to three commands. Depends on atce_pkg.
`default_nettype none

module atce_front #(
  parameter int ESC_LIMIT = 32,
  parameter int MAX_CELLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [7:0]                  char_code,
  input  logic [atce_pkg::CELL_W-1:0] columns,
  input  logic [atce_pkg::CELL_W-1:0] rows,
  output logic                        push,
  output atce_pkg::entry_t            entry
);

  localparam int CW = $clog2(MAX_CELLS);
  localparam int LW = $clog2(ESC_LIMIT);
  localparam int W  = atce_pkg::CELL_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [2:0]    fg_r, fg_nxt;
  logic [2:0]    bg_r, bg_nxt;
  logic          in_esc_r, in_esc_nxt;
  logic [LW-1:0] esc_len_r, esc_len_nxt;
  atce_pkg::esc_phase_t esc_ph_r, esc_ph_nxt;
  logic [7:0]    esc_num_r, esc_num_nxt;
  logic [7:0]    esc_fin_r, esc_fin_nxt;

  logic [W-1:0] eff_cols, eff_rows, rows_m1;
  logic [W-1:0] col9, row9, col_inc, row_inc, col_n9, row_n9;
  logic         is_esc, esc_byte, plain, is_nl, is_bs, is_gl;
  logic         is_alpha, is_digit, over, term, run;
  logic         run_h, run_j, run_k, run_m;
  logic         wrap, nl, scroll;
  logic [7:0]   sel;
  logic [11:0]  num_sum;
  logic [3:0]   dval;
  logic         upd;

  atce_pkg::cmd_t cur_fill, fill_bg, clr_j, clr_k, scr;

  always_comb begin
    eff_cols = columns;
    if (columns == '0) begin
      eff_cols = W'(1);
    end else if (columns > W'(MAX_CELLS)) begin
      eff_cols = W'(MAX_CELLS);
    end
    eff_rows = rows;
    if (rows == '0) begin
      eff_rows = W'(1);
    end else if (rows > W'(MAX_CELLS)) begin
      eff_rows = W'(MAX_CELLS);
    end
  end

  // Decode
  always_comb begin
    rows_m1  = eff_rows - W'(1);
    col9     = W'(col_r);
    row9     = W'(row_r);
    col_inc  = col9 + W'(1);
    row_inc  = row9 + W'(1);
    is_esc   = (char_code == atce_pkg::CH_ESC);
    esc_byte = !is_esc && in_esc_r;
    plain    = !is_esc && !in_esc_r;
    is_nl    = plain && (char_code == atce_pkg::CH_NL);
    is_bs    = plain && (char_code == atce_pkg::CH_BS);
    is_gl    = plain && !is_nl && !is_bs;
    is_alpha = ((char_code >= atce_pkg::CH_UP_A) && (char_code <= atce_pkg::CH_UP_Z))
            || ((char_code >= atce_pkg::CH_LO_A) && (char_code <= atce_pkg::CH_LO_Z));
    is_digit = (char_code >= atce_pkg::CH_ZERO) && (char_code <= atce_pkg::CH_NINE);
    term     = is_alpha || (char_code == atce_pkg::CH_TILDE);
    over     = ({1'b0, esc_len_r} + (LW+1)'(1)) >= (LW+1)'(ESC_LIMIT);
    run      = esc_byte && !over && term
            && ((esc_ph_r == atce_pkg::PH_PARAM) || (esc_ph_r == atce_pkg::PH_FINAL));
    sel      = (esc_ph_r == atce_pkg::PH_PARAM) ? char_code : esc_fin_r;
    run_h    = run && (sel == atce_pkg::CH_UP_H);
    run_j    = run && (sel == atce_pkg::CH_UP_J);
    run_k    = run && (sel == atce_pkg::CH_UP_K);
    run_m    = run && (sel == atce_pkg::CH_LO_M);
    wrap     = is_gl && (col_inc >= eff_cols);
    nl       = is_nl || wrap;
    scroll   = nl && (row_inc >= eff_rows);
    dval     = 4'(char_code - atce_pkg::CH_ZERO);
    num_sum  = 12'(esc_num_r) * 12'd10 + 12'(dval);
  end

  // Next state
  always_comb begin
    col_n9      = col9;
    row_n9      = row9;
    fg_nxt      = fg_r;
    bg_nxt      = bg_r;
    in_esc_nxt  = in_esc_r;
    esc_len_nxt = esc_len_r;
    esc_ph_nxt  = esc_ph_r;
    esc_num_nxt = esc_num_r;
    esc_fin_nxt = esc_fin_r;

    if (run_h || nl) begin
      col_n9 = '0;
    end else if (is_bs && (col9 != '0)) begin
      col_n9 = col9 - W'(1);
    end else if (is_gl) begin
      col_n9 = col_inc;
    end

    if (run_h) begin
      row_n9 = '0;
    end else if (nl) begin
      row_n9 = scroll ? rows_m1 : row_inc;
    end

    if (run_m) begin
      if (esc_num_r == 8'd0) begin
        fg_nxt = atce_pkg::IDX_WHITE;
        bg_nxt = atce_pkg::IDX_BLACK;
      end else if ((esc_num_r >= atce_pkg::SGR_FG_LO) && (esc_num_r <= atce_pkg::SGR_FG_HI)) begin
        fg_nxt = 3'(esc_num_r - atce_pkg::SGR_FG_LO);
      end else if ((esc_num_r >= atce_pkg::SGR_BG_LO) && (esc_num_r <= atce_pkg::SGR_BG_HI)) begin
        bg_nxt = 3'(esc_num_r - atce_pkg::SGR_BG_LO);
      end
    end

    if (is_esc) begin
      in_esc_nxt = 1'b1;
    end else if (esc_byte) begin
      if (over || term) begin
        // end of sequence: parser back to idle
        in_esc_nxt  = 1'b0;
        esc_len_nxt = '0;
        esc_ph_nxt  = atce_pkg::PH_BRACKET;
        esc_num_nxt = '0;
        esc_fin_nxt = '0;
      end else begin
        esc_len_nxt = esc_len_r + LW'(1);
        unique case (esc_ph_r)
          atce_pkg::PH_BRACKET: begin
            esc_ph_nxt = (char_code == atce_pkg::CH_LBRACK) ? atce_pkg::PH_PARAM
                                                            : atce_pkg::PH_REJECT;
          end
          atce_pkg::PH_PARAM: begin
            if (is_digit) begin
              esc_num_nxt = (num_sum > 12'd255) ? 8'd255 : num_sum[7:0];
            end else begin
              esc_fin_nxt = char_code;
              esc_ph_nxt  = atce_pkg::PH_FINAL;
            end
          end
          atce_pkg::PH_FINAL,
          atce_pkg::PH_REJECT: begin
          end
          default: begin
          end
        endcase
      end
    end

    col_nxt = col_n9[CW-1:0];
    row_nxt = row_n9[CW-1:0];
  end

  // Command list
  always_comb begin
    cur_fill = atce_pkg::mk_cmd(atce_pkg::OP_FILL, 8'd0, col_n9, row_n9, '0, '0, fg_nxt, 3'd0);
    fill_bg  = atce_pkg::mk_cmd(atce_pkg::OP_FILL, 8'd0, col9, row9, '0, '0, bg_r, 3'd0);
    clr_j    = atce_pkg::mk_cmd(atce_pkg::OP_CLEAR, 8'd0, '0, row_inc, eff_cols, eff_rows,
                                bg_r, 3'd0);
    clr_k    = atce_pkg::mk_cmd(atce_pkg::OP_CLEAR, 8'd0, col9, row9, eff_cols, row_inc,
                                bg_r, 3'd0);
    scr      = atce_pkg::mk_cmd(atce_pkg::OP_SCROLL, 8'd0, '0, '0, '0, '0, bg_r, 3'd0);

    entry        = '0;
    entry.cmd[0] = cur_fill;
    entry.cnt    = atce_pkg::SLOT_W'(1);
    if (run_j) begin
      entry.cmd[0] = clr_j;
      entry.cmd[1] = clr_k;
      entry.cmd[2] = cur_fill;
      entry.cnt    = atce_pkg::SLOT_W'(3);
    end else if (run_k) begin
      entry.cmd[0] = clr_k;
      entry.cmd[1] = cur_fill;
      entry.cnt    = atce_pkg::SLOT_W'(2);
    end else if (is_bs) begin
      entry.cmd[0] = fill_bg;
      entry.cmd[1] = atce_pkg::mk_cmd(atce_pkg::OP_GLYPH, atce_pkg::CH_SPACE, col_n9, row9,
                                      '0, '0, fg_r, bg_r);
      entry.cmd[2] = cur_fill;
      entry.cnt    = atce_pkg::SLOT_W'(3);
    end else if (is_nl || is_gl) begin
      entry.cmd[0] = is_nl ? fill_bg
                   : atce_pkg::mk_cmd(atce_pkg::OP_GLYPH, char_code, col9, row9,
                                      '0, '0, fg_r, bg_r);
      if (scroll) begin
        entry.cmd[1] = scr;
        entry.cmd[2] = cur_fill;
        entry.cnt    = atce_pkg::SLOT_W'(3);
      end else begin
        entry.cmd[1] = cur_fill;
        entry.cnt    = atce_pkg::SLOT_W'(2);
      end
    end
  end

  // A null byte is taken and dropped
  assign upd  = take && (char_code != atce_pkg::CH_NUL);
  assign push = upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      fg_r      <= atce_pkg::IDX_WHITE;
      bg_r      <= atce_pkg::IDX_BLACK;
      in_esc_r  <= 1'b0;
      esc_len_r <= '0;
      esc_ph_r  <= atce_pkg::PH_BRACKET;
      esc_num_r <= '0;
      esc_fin_r <= '0;
    end else if (upd) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
      in_esc_r  <= in_esc_nxt;
      esc_len_r <= esc_len_nxt;
      esc_ph_r  <= esc_ph_nxt;
      esc_num_r <= esc_num_nxt;
      esc_fin_r <= esc_fin_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/atce_back.sv
// Back end: walks the commands of the head queue entry, encodes colours
// and holds each command in the output register. Depends on atce_pkg.
`default_nettype none

module atce_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_nonempty,
  input  atce_pkg::entry_t            q_head,
  output logic                        q_pop,
  input  atce_pkg::clr_cfg_t          clr_cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_op,
  output logic [7:0]                  out_glyph_code,
  output logic [atce_pkg::CELL_W-1:0] out_col_start,
  output logic [atce_pkg::CELL_W-1:0] out_row_start,
  output logic [atce_pkg::CELL_W-1:0] out_col_end,
  output logic [atce_pkg::CELL_W-1:0] out_row_end,
  output logic [31:0]                 out_fg_color,
  output logic [31:0]                 out_bg_color,
  output logic [31:0]                 out_fill_color,
  output logic                        out_last
);

  logic [atce_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        valid_r, valid_nxt;
  atce_pkg::cmd_t              cmd;
  logic                        is_last, load, is_glyph;
  logic [31:0]                 enc_a, enc_b;

  logic [1:0]                  op_r;
  logic [7:0]                  glyph_r;
  logic [atce_pkg::CELL_W-1:0] c0_r, r0_r, c1_r, r1_r;
  logic [31:0]                 fg_r, bg_r, fill_r;
  logic                        last_r;

  always_comb begin
    cmd      = q_head.cmd[slot_r];
    is_last  = (slot_r == q_head.cnt - atce_pkg::SLOT_W'(1));
    load     = q_nonempty && (!valid_r || !out_stall);
    q_pop    = load && is_last;
    slot_nxt = load ? (is_last ? '0 : slot_r + atce_pkg::SLOT_W'(1)) : slot_r;
    // hold while stalled, drop once taken
    valid_nxt = load ? 1'b1 : (valid_r && out_stall);
    is_glyph = (cmd.op == atce_pkg::OP_GLYPH);
    enc_a    = atce_pkg::encode(cmd.idx_a, clr_cfg);
    enc_b    = atce_pkg::encode(cmd.idx_b, clr_cfg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r    <= cmd.op;
      glyph_r <= cmd.glyph;
      c0_r    <= cmd.c0;
      r0_r    <= cmd.r0;
      c1_r    <= cmd.c1;
      r1_r    <= cmd.r1;
      fg_r    <= is_glyph ? enc_a : 32'd0;
      bg_r    <= is_glyph ? enc_b : 32'd0;
      fill_r  <= is_glyph ? 32'd0 : enc_a;
      last_r  <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_op         = op_r;
  assign out_glyph_code = glyph_r;
  assign out_col_start  = c0_r;
  assign out_row_start  = r0_r;
  assign out_col_end    = c1_r;
  assign out_row_end    = r1_r;
  assign out_fg_color   = fg_r;
  assign out_bg_color   = bg_r;
  assign out_fill_color = fill_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

>>> sv/atce_checker.sv
// Port-level checker for the console engine, bound to the top level.
// Depends on atce_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module atce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_op,
  input wire logic [8:0]  out_col_start,
  input wire logic [31:0] out_fill_color,
  input wire logic        out_last
);

  // a stalled beat keeps its contents
  `ATCE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_op) && $stable(out_col_start) && $stable(out_fill_color) && $stable(out_last))

  // nothing leaves in the cycle after reset
  `ATCE_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_valid)

  // every character closes with its cursor block
  `ATCE_ASSERT(a_last_is_fill, clk, rst_n, out_valid && out_last |-> out_op == atce_pkg::OP_FILL)

  // a scroll is never the last command of its character and starts at column 0
  `ATCE_ASSERT(a_scroll_not_last, clk, rst_n, out_valid && out_op == atce_pkg::OP_SCROLL |-> !out_last && out_col_start == 9'd0)

endmodule

bind ansi_text_console_engine_top atce_checker u_atce_checker (.*);

`default_nettype wire
